FILE: rtl/core/bps_pkg.sv
// shared types and constants for the byte pattern search block
`default_nettype none

package bps_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int MAX_MATCHES = 8;
  localparam int WINDOW_DEPTH = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] POS_MAX = 16'hFFFF;
  localparam logic [3:0] LEN_LIMIT = 4'(PATTERN_MAX);
  localparam logic [3:0] MATCH_LIMIT = 4'(MAX_MATCHES);

  typedef enum logic [1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_START_POSITION = 2'd2
  } cfg_index_t;

  typedef enum logic {
    KIND_MATCH   = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_word_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [15:0]  head_position;
    logic [16:0]  end_position;
    logic [15:0]  segment_length;
    logic         segment_valid;
    logic [3:0]   match_total;
    logic         overflow_flag;
    logic         final_result;
  } result_word_t;

  typedef struct packed {
    logic         push_a;
    logic         push_b;
    result_word_t word_a;
    result_word_t word_b;
  } queue_push_t;

  typedef struct packed {
    logic [QUEUE_CNT_W-1:0] count;
    logic                   room;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/byte_pattern_search.sv
// top level of the byte pattern search: input register, search engine, result queue
//
//   channel  | direction | handshake                 | word
//   ---------+-----------+---------------------------+-----------------------------
//   byte     | in        | byte_valid / byte_stall   | byte_word (data_byte, last_byte)
//   result   | out       | result_valid/result_stall | result_word (match or summary)
//   cfg      | in        | cfg_write                 | cfg_index, cfg_data
//
// one byte per cycle while byte_stall is low; a byte enters the input register,
// and once the queue has room the engine compares the whole window and pushes
// zero, one or two results into a four-word queue. result_valid is driven from
// the registered queue count, so it rises once a pushed word has been written.
// a byte leaves the input register only while the queue has room for two words,
// so a stalled result side backs up into byte_stall when more than two words wait.
// synchronous reset clears the search state, the configuration and the queue.
`default_nettype none

module byte_pattern_search (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [63:0]           cfg_data,
  input  wire logic                  byte_valid,
  output logic                       byte_stall,
  input  wire bps_pkg::byte_word_t   byte_word,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output bps_pkg::result_word_t      result_word
);

  bps_pkg::byte_word_t    in_reg;
  logic                   in_reg_valid;
  logic                   take;
  bps_pkg::queue_push_t   push;
  bps_pkg::queue_status_t status;

  assign take       = in_reg_valid && status.room;
  assign byte_stall = in_reg_valid && !status.room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!byte_stall) begin
      in_reg_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_reg <= byte_word;
    end
  end

  bps_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .word      (in_reg),
    .push      (push)
  );

  bps_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    status.count <= bps_pkg::QUEUE_CNT_W'(bps_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_push_needs_take: assert property (@(posedge clk) disable iff (rst)
    (push.push_a || push.push_b) |-> take)
    else $error("result pushed without a byte taken");

  a_valid_tracks_count: assert property (@(posedge clk) disable iff (rst)
    result_valid == (status.count != '0))
    else $error("result_valid disagrees with queue fill");

  a_summary_closes: assert property (@(posedge clk) disable iff (rst)
    push.push_b |-> push.word_b.final_result && (!push.push_a || !push.word_a.final_result))
    else $error("summary not marked as the closing word");

endmodule

`default_nettype wire

FILE: rtl/core/bps_engine.sv
// search state, window compare and result formation for one byte
`default_nettype none

module bps_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire logic               take,
  input  wire bps_pkg::byte_word_t word,
  output bps_pkg::queue_push_t    push
);

  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [15:0] start_position;

  logic [7:0]  history_window [bps_pkg::WINDOW_DEPTH];
  logic [15:0] byte_position;
  logic [15:0] previous_head;
  logic [3:0]  match_counter;
  logic        overflow_seen;

  logic [7:0]  window_next [bps_pkg::WINDOW_DEPTH];
  logic [15:0] byte_position_next;
  logic [15:0] previous_head_next;
  logic [3:0]  match_counter_next;
  logic        overflow_seen_next;

  logic [3:0]  len;
  logic [15:0] idx;
  logic [16:0] idx_plus;
  logic [16:0] head_wide;
  logic [15:0] head;
  logic        window_hit;
  logic        hit;
  logic        seg_ok;
  logic [15:0] blen;
  logic        sum_segv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= 4'd1;
      start_position <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bps_pkg::CFG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        bps_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[3:0];
        bps_pkg::CFG_START_POSITION: start_position <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len = (pattern_length > bps_pkg::LEN_LIMIT) ? bps_pkg::LEN_LIMIT : pattern_length;

    window_next[0] = word.data_byte;
    for (int j = 1; j < bps_pkg::WINDOW_DEPTH; j++) begin
      window_next[j] = history_window[j-1];
    end

    if (byte_position == bps_pkg::POS_MAX) begin
      overflow_seen_next = 1'b1;
      idx                = bps_pkg::POS_MAX;
      byte_position_next = byte_position;
    end else begin
      overflow_seen_next = overflow_seen;
      idx                = byte_position;
      byte_position_next = byte_position + 16'd1;
    end

    idx_plus  = {1'b0, idx} + 17'd1;
    head_wide = idx_plus - {13'd0, len};
    head      = head_wide[15:0];

    // pattern byte k sits len-1-k bytes back in the window
    window_hit = 1'b1;
    for (int k = 0; k < bps_pkg::PATTERN_MAX; k++) begin
      if (4'(k) < len) begin
        if (window_next[3'(len - 4'd1 - 4'(k))] != pattern_bytes[8*k +: 8]) begin
          window_hit = 1'b0;
        end
      end
    end

    hit = !overflow_seen_next && (len != 4'd0) && (idx_plus >= {13'd0, len}) &&
          (match_counter < bps_pkg::MATCH_LIMIT) && (head >= start_position) &&
          window_hit;

    seg_ok             = match_counter != 4'd0;
    match_counter_next = hit ? match_counter + 4'd1 : match_counter;
    previous_head_next = hit ? head : previous_head;

    blen     = overflow_seen_next ? bps_pkg::POS_MAX : byte_position_next;
    sum_segv = (match_counter_next != 4'd0) && (match_counter_next < bps_pkg::MATCH_LIMIT);

    push.push_a                = take && hit;
    push.word_a.result_kind    = bps_pkg::KIND_MATCH;
    push.word_a.head_position  = head;
    push.word_a.end_position   = idx_plus;
    push.word_a.segment_length = seg_ok ? head - previous_head : 16'd0;
    push.word_a.segment_valid  = seg_ok;
    push.word_a.match_total    = match_counter_next;
    push.word_a.overflow_flag  = overflow_seen_next;
    push.word_a.final_result   = !word.last_byte;

    push.push_b                = take && word.last_byte;
    push.word_b.result_kind    = bps_pkg::KIND_SUMMARY;
    push.word_b.head_position  = '0;
    push.word_b.end_position   = '0;
    push.word_b.segment_length = (sum_segv && blen >= previous_head_next) ?
                                 blen - previous_head_next : 16'd0;
    push.word_b.segment_valid  = sum_segv;
    push.word_b.match_total    = match_counter_next;
    push.word_b.overflow_flag  = overflow_seen_next;
    push.word_b.final_result   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && word.last_byte)) begin
      for (int j = 0; j < bps_pkg::WINDOW_DEPTH; j++) begin
        history_window[j] <= '0;
      end
      byte_position <= '0;
      previous_head <= '0;
      match_counter <= '0;
      overflow_seen <= 1'b0;
    end else if (take) begin
      history_window <= window_next;
      byte_position  <= byte_position_next;
      previous_head  <= previous_head_next;
      match_counter  <= match_counter_next;
      overflow_seen  <= overflow_seen_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bps_queue.sv
// small result queue taking up to two words per cycle and giving one per cycle while result_stall is low
`default_nettype none

module bps_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bps_pkg::queue_push_t  push,
  output bps_pkg::queue_status_t     status,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output bps_pkg::result_word_t      result_word
);

  bps_pkg::result_word_t entries [bps_pkg::QUEUE_DEPTH];

  logic [bps_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [bps_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [bps_pkg::QUEUE_CNT_W-1:0] count;
  logic [bps_pkg::QUEUE_CNT_W-1:0] count_next;
  logic [bps_pkg::QUEUE_PTR_W-1:0] wr_ptr_b;
  logic                            pop;

  always_comb begin
    pop        = result_valid && !result_stall;
    wr_ptr_b   = wr_ptr + bps_pkg::QUEUE_PTR_W'(push.push_a);
    count_next = count + bps_pkg::QUEUE_CNT_W'(push.push_a)
                       + bps_pkg::QUEUE_CNT_W'(push.push_b)
                       - bps_pkg::QUEUE_CNT_W'(pop);
    result_valid = count != '0;
    result_word  = entries[rd_ptr];
    status.count = count;
    status.room  = count <= bps_pkg::QUEUE_CNT_W'(bps_pkg::QUEUE_DEPTH - 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + bps_pkg::QUEUE_PTR_W'(1);
      end
      wr_ptr <= wr_ptr_b + bps_pkg::QUEUE_PTR_W'(push.push_b);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push_a) begin
      entries[wr_ptr] <= push.word_a;
    end
    if (push.push_b) begin
      entries[wr_ptr_b] <= push.word_b;
    end
  end

endmodule

`default_nettype wire
